FILE: sv/mrv_pkg.sv
package mrv_pkg;

  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_DECODE = 1'b1
  } action_e;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_VALUE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ENC_STEP,
    BK_ENC_EMIT
  } back_state_e;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned RADIX_W = 7;
  localparam int unsigned LIMIT_W = 9;
  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned RECIP_W = 33;
  localparam int unsigned RECIP_SHIFT = 39;

  localparam logic [COUNT_W-1:0] LAST_POS = 3'd4;

  localparam logic [RADIX_W-1:0] SHIFT_RADIX = 7'd32;
  localparam int unsigned SHIFT_RADIX_LOG2 = 5;

  localparam logic [LIMIT_W-1:0] BYTE_SPAN = 9'd256;
  localparam logic [LIMIT_W-1:0] BYTE_MAX = 9'd255;

  // smallest value that needs more than n bytes
  localparam logic [VALUE_W-1:0] LEN1_BOUND = 32'd178;
  localparam logic [VALUE_W-1:0] LEN2_BOUND = 32'd12736;
  localparam logic [VALUE_W-1:0] LEN3_BOUND = 32'd1672576;
  localparam logic [VALUE_W-1:0] LEN4_BOUND = 32'd45776896;

  localparam logic [RECIP_W-1:0] RECIP_78 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd77) / 64'd78);
  localparam logic [RECIP_W-1:0] RECIP_95 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd94) / 64'd95);
  localparam logic [RECIP_W-1:0] RECIP_70 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd69) / 64'd70);

  typedef struct packed {
    action_e                action;
    logic [VALUE_W-1:0]     data;
    logic [COUNT_W-1:0]     count;
  } entry_t;

  typedef struct packed {
    kind_e                  kind;
    logic [BYTE_W-1:0]      byte_out;
    logic [VALUE_W-1:0]     value;
    logic [COUNT_W-1:0]     count;
    logic                   last;
  } result_t;

  function automatic logic [RADIX_W-1:0] radix_f(input logic [COUNT_W-1:0] pos);
    logic [RADIX_W-1:0] r;
    unique case (pos)
      3'd0:    r = 7'd78;
      3'd1:    r = 7'd95;
      3'd2:    r = 7'd32;
      3'd3:    r = 7'd70;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [WEIGHT_W-1:0] weight_f(input logic [COUNT_W-1:0] pos);
    logic [WEIGHT_W-1:0] w;
    unique case (pos)
      3'd0:    w = 24'd1;
      3'd1:    w = 24'd78;
      3'd2:    w = 24'd7410;
      3'd3:    w = 24'd237120;
      default: w = 24'd16598400;
    endcase
    return w;
  endfunction

  // radix 32 goes through a shift, so it has no reciprocal
  function automatic logic [RECIP_W-1:0] recip_f(input logic [COUNT_W-1:0] pos);
    logic [RECIP_W-1:0] m;
    unique case (pos)
      3'd0:    m = RECIP_78;
      3'd1:    m = RECIP_95;
      3'd3:    m = RECIP_70;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/mrv_fifo.sv
module mrv_fifo
  import mrv_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/mrv_front.sv
module mrv_front
  import mrv_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                action_i,
  input  logic [VALUE_W-1:0]  value_in_i,
  input  logic [BYTE_W-1:0]   byte_in_i,
  input  logic                pop_i,
  output logic                empty_o,
  output entry_t              entry_o
);

  localparam int unsigned ENTRY_W = $bits(entry_t);

  entry_t             entry_in;
  logic [COUNT_W-1:0] enc_len;
  logic [ENTRY_W-1:0] head;

  // encoded length straight from the value range
  always_comb begin
    priority if (value_in_i < LEN1_BOUND) begin
      enc_len = 3'd1;
    end else if (value_in_i < LEN2_BOUND) begin
      enc_len = 3'd2;
    end else if (value_in_i < LEN3_BOUND) begin
      enc_len = 3'd3;
    end else if (value_in_i < LEN4_BOUND) begin
      enc_len = 3'd4;
    end else begin
      enc_len = 3'd5;
    end
  end

  always_comb begin
    entry_in.action = action_e'(action_i);
    if (action_e'(action_i) == ACT_ENCODE) begin
      entry_in.data  = value_in_i;
      entry_in.count = enc_len;
    end else begin
      entry_in.data  = {{(VALUE_W-BYTE_W){1'b0}}, byte_in_i};
      entry_in.count = '0;
    end
  end

  mrv_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (entry_in),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .data_o  (head),
    .empty_o (empty_o)
  );

  assign entry_o = entry_t'(head);

endmodule

FILE: sv/mrv_back.sv
module mrv_back
  import mrv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_empty_i,
  input  entry_t  in_entry_i,
  output logic    in_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  back_state_e state_q, state_d;

  logic [VALUE_W-1:0] enc_val_q, enc_val_d;
  logic [VALUE_W-1:0] enc_rem_q, enc_rem_d;
  logic [VALUE_W-1:0] enc_quo_q, enc_quo_d;
  logic [COUNT_W-1:0] enc_pos_q, enc_pos_d;
  logic [COUNT_W-1:0] enc_cnt_q, enc_cnt_d;
  logic [VALUE_W-1:0] dec_acc_q, dec_acc_d;
  logic [COUNT_W-1:0] dec_pos_q, dec_pos_d;

  logic                     is_encode;
  logic [COUNT_W-1:0]       dec_pos;
  logic [RADIX_W-1:0]       dec_radix;
  logic [LIMIT_W-1:0]       dec_lim;
  logic [BYTE_W-1:0]        dec_byte;
  logic                     dec_final;
  logic [LIMIT_W-1:0]       dec_term;
  logic [LIMIT_W+WEIGHT_W-1:0] dec_prod;
  logic [VALUE_W-1:0]       dec_sum;

  logic                     enc_final;
  logic [RADIX_W-1:0]       enc_radix;
  logic [LIMIT_W-1:0]       enc_lim;
  logic [VALUE_W-1:0]       enc_diff;
  logic [VALUE_W+RECIP_W-1:0] enc_prod;
  logic [VALUE_W-1:0]       enc_quo;
  logic [VALUE_W-1:0]       enc_back;
  logic [VALUE_W-1:0]       enc_digit;
  logic [BYTE_W-1:0]        enc_byte;

  assign is_encode = (in_entry_i.action == ACT_ENCODE);

  // decode datapath
  assign dec_pos   = (dec_pos_q > LAST_POS) ? LAST_POS : dec_pos_q;
  assign dec_radix = radix_f(dec_pos);
  assign dec_lim   = BYTE_SPAN - LIMIT_W'(dec_radix);
  assign dec_byte  = in_entry_i.data[BYTE_W-1:0];
  assign dec_final = (dec_radix == '0) || (LIMIT_W'(dec_byte) < dec_lim);
  assign dec_term  = dec_final ? LIMIT_W'(dec_byte)
                               : dec_lim + BYTE_MAX - LIMIT_W'(dec_byte);
  assign dec_prod  = (LIMIT_W+WEIGHT_W)'(dec_term) * (LIMIT_W+WEIGHT_W)'(weight_f(dec_pos));
  assign dec_sum   = dec_acc_q + dec_prod[VALUE_W-1:0];

  // encode datapath
  assign enc_final = (enc_pos_q == enc_cnt_q - 3'd1);
  assign enc_radix = radix_f(enc_pos_q);
  assign enc_lim   = BYTE_SPAN - LIMIT_W'(enc_radix);
  assign enc_diff  = enc_val_q - VALUE_W'(enc_lim);
  assign enc_prod  = (VALUE_W+RECIP_W)'(enc_diff) * (VALUE_W+RECIP_W)'(recip_f(enc_pos_q));
  assign enc_quo   = (enc_radix == SHIFT_RADIX) ? (enc_diff >> SHIFT_RADIX_LOG2)
                                                : VALUE_W'(enc_prod >> RECIP_SHIFT);
  assign enc_back  = VALUE_W'(enc_quo_q * VALUE_W'(enc_radix));
  assign enc_digit = enc_rem_q - enc_back;
  assign enc_byte  = BYTE_W'(BYTE_MAX) - enc_digit[BYTE_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!in_empty_i && is_encode) begin
          state_d = BK_ENC_STEP;
        end
      end
      BK_ENC_STEP: begin
        if (!enc_final) begin
          state_d = BK_ENC_EMIT;
        end else if (!res_full_i) begin
          state_d = BK_IDLE;
        end
      end
      BK_ENC_EMIT: begin
        if (!res_full_i) begin
          state_d = BK_ENC_STEP;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    in_pop_o   = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{kind: KIND_BYTE, byte_out: '0, value: '0, count: enc_cnt_q, last: 1'b0};
    unique case (state_q)
      BK_IDLE: begin
        if (!in_empty_i) begin
          if (is_encode) begin
            in_pop_o = 1'b1;
          end else if (!dec_final) begin
            in_pop_o = 1'b1;
          end else if (!res_full_i) begin
            in_pop_o   = 1'b1;
            res_push_o = 1'b1;
            res_o      = '{kind: KIND_VALUE, byte_out: '0, value: dec_sum,
                           count: dec_pos + 3'd1, last: 1'b1};
          end
        end
      end
      BK_ENC_STEP: begin
        if (enc_final && !res_full_i) begin
          res_push_o    = 1'b1;
          res_o.byte_out = enc_val_q[BYTE_W-1:0];
          res_o.last    = 1'b1;
        end
      end
      BK_ENC_EMIT: begin
        if (!res_full_i) begin
          res_push_o     = 1'b1;
          res_o.byte_out = enc_byte;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    enc_val_d = enc_val_q;
    enc_rem_d = enc_rem_q;
    enc_quo_d = enc_quo_q;
    enc_pos_d = enc_pos_q;
    enc_cnt_d = enc_cnt_q;
    dec_acc_d = dec_acc_q;
    dec_pos_d = dec_pos_q;
    unique case (state_q)
      BK_IDLE: begin
        if (in_pop_o) begin
          if (is_encode) begin
            enc_val_d = in_entry_i.data;
            enc_pos_d = '0;
            enc_cnt_d = in_entry_i.count;
          end else if (dec_final) begin
            dec_acc_d = '0;
            dec_pos_d = '0;
          end else begin
            dec_acc_d = dec_sum;
            dec_pos_d = dec_pos + 3'd1;
          end
        end
      end
      BK_ENC_STEP: begin
        if (!enc_final) begin
          enc_rem_d = enc_diff;
          enc_quo_d = enc_quo;
        end
      end
      BK_ENC_EMIT: begin
        if (res_push_o) begin
          enc_val_d = enc_quo_q;
          enc_pos_d = enc_pos_q + 3'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      enc_pos_q <= '0;
      enc_cnt_q <= '0;
      dec_acc_q <= '0;
      dec_pos_q <= '0;
    end else begin
      state_q   <= state_d;
      enc_pos_q <= enc_pos_d;
      enc_cnt_q <= enc_cnt_d;
      dec_acc_q <= dec_acc_d;
      dec_pos_q <= dec_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    enc_val_q <= enc_val_d;
    enc_rem_q <= enc_rem_d;
    enc_quo_q <= enc_quo_d;
  end

endmodule

FILE: sv/mixed_radix_varint_codec.sv
// Mixed-radix variable-length integer codec. Encode items (action_i low) turn a 32-bit
// value into 1 to 5 bytes, one result item per byte, each carrying the total length
// and last_o on the final byte; decode items (action_i high) feed one byte into a kept
// accumulator and produce one result item with the value and byte count when the
// final byte arrives. Items enter a short input queue and are classified there
// (encode length comes from range compares), then an engine takes one at a time and
// writes results into a short result queue. A decode byte is taken in the idle state.
// An encode item is loaded in the idle state, then each non-final byte takes a step of
// reciprocal multiplication (a shift for radix 32) and a step of remainder and emit,
// and a last step emits the final byte. A full result queue stalls the engine.
module mixed_radix_varint_codec
  import mrv_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = 2,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               action_i,
  input  logic [VALUE_W-1:0] value_in_i,
  input  logic [BYTE_W-1:0]  byte_in_i,
  output logic               empty,
  input  logic               pop,
  output logic               kind_o,
  output logic [BYTE_W-1:0]  byte_out_o,
  output logic [VALUE_W-1:0] value_out_o,
  output logic [COUNT_W-1:0] byte_count_o,
  output logic               last_o
);

  localparam int unsigned RESULT_W = $bits(result_t);

  entry_t              entry;
  logic                entry_empty;
  logic                entry_pop;
  logic                res_full;
  logic                res_push;
  result_t             res_in;
  logic [RESULT_W-1:0] res_head;
  result_t             res_out;

  mrv_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .action_i   (action_i),
    .value_in_i (value_in_i),
    .byte_in_i  (byte_in_i),
    .pop_i      (entry_pop),
    .empty_o    (entry_empty),
    .entry_o    (entry)
  );

  mrv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_empty_i (entry_empty),
    .in_entry_i (entry),
    .in_pop_o   (entry_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  mrv_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (RESULT_DEPTH)
  ) u_results (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign res_out      = result_t'(res_head);
  assign kind_o       = res_out.kind;
  assign byte_out_o   = res_out.byte_out;
  assign value_out_o  = res_out.value;
  assign byte_count_o = res_out.count;
  assign last_o       = res_out.last;

endmodule
